// ===== sv/sva_pkg.sv =====
// Shared types, codes and sizes for the voice allocator.
package sva_pkg;

  localparam int VOICES = 8;
  localparam int IDX_W  = $clog2(VOICES);
  localparam int CNT_W  = IDX_W + 1;
  localparam int STAMP_W = 32;

  localparam logic [IDX_W-1:0] NOISE_CH = IDX_W'(7);

  // request opcodes
  localparam logic [1:0] OP_NOTE_ON  = 2'd0;
  localparam logic [1:0] OP_NOTE_OFF = 2'd1;
  localparam logic [1:0] OP_REL_ALL  = 2'd2;

  // result status codes
  localparam logic [2:0] STS_FREE      = 3'd0;
  localparam logic [2:0] STS_RETRIG    = 3'd1;
  localparam logic [2:0] STS_STOLEN    = 3'd2;
  localparam logic [2:0] STS_RELEASED  = 3'd3;
  localparam logic [2:0] STS_NOT_FOUND = 3'd4;
  localparam logic [2:0] STS_ALL_REL   = 3'd5;

  // steal policies
  localparam logic [1:0] POL_OLDEST   = 2'd0;
  localparam logic [1:0] POL_QUIETEST = 2'd1;
  localparam logic [1:0] POL_LOW_NOTE = 2'd2;

  typedef struct packed {
    logic [6:0]         note;
    logic [6:0]         velocity;
    logic [STAMP_W-1:0] stamp;
  } voice_entry_t;

  typedef struct packed {
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    voice_entry_t       wr_data;
  } tbl_req_t;

  typedef struct packed {
    logic             done;
    logic             hit_found;
    logic [IDX_W-1:0] hit_idx;
    logic [IDX_W-1:0] best_idx;
  } scan_res_t;

  typedef struct packed {
    logic [2:0] channel;
    logic [2:0] status;
  } res_t;

endpackage

// ===== sv/sva_scan.sv =====
// Voice table memory and the per-entry match and victim tracking of a scan.
module sva_scan import sva_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  tbl_req_t            tbl_req,
  input  logic                start,
  input  logic [6:0]          match_note,
  input  logic [1:0]          steal_policy,
  input  logic [VOICES-1:0]   active,
  output scan_res_t           scan_res
);

  voice_entry_t mem [VOICES];

  voice_entry_t       rdata_r;
  logic               rd_vld_r;
  logic [IDX_W-1:0]   rd_idx_r;
  logic               hit_found_r;
  logic [IDX_W-1:0]   hit_idx_r;
  logic [IDX_W-1:0]   best_idx_r;
  logic [STAMP_W-1:0] best_key_r;

  logic [STAMP_W-1:0] key;
  logic               better;
  logic               is_hit;

  // writes only happen after a scan has finished, so no read ever sees a write in flight
  always_ff @(posedge clk) begin
    if (tbl_req.wr_en) begin
      mem[tbl_req.wr_addr] <= tbl_req.wr_data;
    end
    if (tbl_req.rd_en) begin
      rdata_r <= mem[tbl_req.rd_addr];
    end
  end

  always_comb begin
    case (steal_policy)
      POL_OLDEST:   key = rdata_r.stamp;
      POL_QUIETEST: key = STAMP_W'(rdata_r.velocity);
      POL_LOW_NOTE: key = STAMP_W'(rdata_r.note);
      default:      key = '0;
    endcase
    // strict compare keeps the lowest index on ties
    better = (rd_idx_r == '0) || (key < best_key_r);
    is_hit = !hit_found_r && active[rd_idx_r] && (rdata_r.note == match_note);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r    <= 1'b0;
      hit_found_r <= 1'b0;
    end else begin
      rd_vld_r <= tbl_req.rd_en;
      if (start) begin
        hit_found_r <= 1'b0;
      end else if (rd_vld_r && is_hit) begin
        hit_found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= tbl_req.rd_addr;
    if (rd_vld_r) begin
      if (is_hit) begin
        hit_idx_r <= rd_idx_r;
      end
      if (better) begin
        best_idx_r <= rd_idx_r;
        best_key_r <= key;
      end
    end
  end

  assign scan_res.done      = rd_vld_r && (rd_idx_r == IDX_W'(VOICES - 1));
  assign scan_res.hit_found = hit_found_r;
  assign scan_res.hit_idx   = hit_idx_r;
  assign scan_res.best_idx  = best_idx_r;

endmodule

// ===== sv/sva_ctrl.sv =====
// Request sequencer: table scan, allocation decision, write-back and active flags.
module sva_ctrl import sva_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_op,
  input  logic [6:0]        in_note,
  input  logic [6:0]        in_velocity,
  input  logic              in_needs_noise,
  input  logic [1:0]        steal_policy,
  output logic              res_valid,
  input  logic              res_ready,
  output res_t              res
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_t;

  state_t             state_r, state_nxt;
  logic [1:0]         op_r;
  logic [6:0]         note_r;
  logic [6:0]         vel_r;
  logic               noise_r;
  logic [VOICES-1:0]  active_r;
  logic [STAMP_W-1:0] stamp_r;
  logic [CNT_W-1:0]   scan_cnt_r;

  tbl_req_t           tbl_req;
  scan_res_t          scan_res;
  logic               accept;
  logic               fire;
  logic [STAMP_W-1:0] stamp_inc;
  logic               free_found;
  logic [IDX_W-1:0]   free_idx;
  logic [IDX_W-1:0]   tgt_idx;
  logic [2:0]         status;
  logic               do_wr;
  logic               do_set;
  logic               do_clr;
  logic               do_clr_all;

  sva_scan u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .tbl_req      (tbl_req),
    .start        (accept),
    .match_note   (note_r),
    .steal_policy (steal_policy),
    .active       (active_r),
    .scan_res     (scan_res)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign res_valid = (state_r == ST_DONE);
  assign fire      = res_valid && res_ready;
  assign stamp_inc = stamp_r + STAMP_W'(1);

  // highest-numbered free voice
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < VOICES; i++) begin
      if (!active_r[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  always_comb begin
    tgt_idx    = '0;
    status     = STS_NOT_FOUND;
    do_wr      = 1'b0;
    do_set     = 1'b0;
    do_clr     = 1'b0;
    do_clr_all = 1'b0;
    case (op_r)
      OP_NOTE_ON: begin
        do_wr  = 1'b1;
        do_set = 1'b1;
        if (scan_res.hit_found) begin
          tgt_idx = scan_res.hit_idx;
          status  = STS_RETRIG;
        end else if (noise_r) begin
          tgt_idx = NOISE_CH;
          status  = active_r[NOISE_CH] ? STS_STOLEN : STS_FREE;
        end else if (free_found) begin
          tgt_idx = free_idx;
          status  = STS_FREE;
        end else begin
          tgt_idx = scan_res.best_idx;
          status  = STS_STOLEN;
        end
      end
      OP_NOTE_OFF: begin
        if (scan_res.hit_found) begin
          tgt_idx = scan_res.hit_idx;
          status  = STS_RELEASED;
          do_clr  = 1'b1;
        end
      end
      OP_REL_ALL: begin
        status     = STS_ALL_REL;
        do_clr_all = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign res.channel = tgt_idx[2:0];
  assign res.status  = status;

  always_comb begin
    tbl_req.rd_en            = (state_r == ST_SCAN) && (scan_cnt_r < CNT_W'(VOICES));
    tbl_req.rd_addr          = scan_cnt_r[IDX_W-1:0];
    tbl_req.wr_en            = fire && do_wr;
    tbl_req.wr_addr          = tgt_idx;
    tbl_req.wr_data.note     = note_r;
    tbl_req.wr_data.velocity = vel_r;
    tbl_req.wr_data.stamp    = stamp_inc;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ((in_op == OP_NOTE_ON) || (in_op == OP_NOTE_OFF)) ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (scan_res.done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      active_r   <= '0;
      stamp_r    <= '0;
      scan_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        scan_cnt_r <= '0;
      end else if (tbl_req.rd_en) begin
        scan_cnt_r <= scan_cnt_r + CNT_W'(1);
      end
      if (fire) begin
        if (do_clr_all) begin
          active_r <= '0;
        end else if (do_set) begin
          active_r[tgt_idx] <= 1'b1;
        end else if (do_clr) begin
          active_r[tgt_idx] <= 1'b0;
        end
        if (op_r == OP_NOTE_ON) begin
          stamp_r <= stamp_inc;
        end
      end
    end
  end

  // hold the request fields for the whole operation
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_op;
      note_r  <= in_note;
      vel_r   <= in_velocity;
      noise_r <= in_needs_noise;
    end
  end

  a_note_on_marks_active: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (op_r == OP_NOTE_ON)) |=>
      (active_r[$past(tgt_idx)] && (stamp_r == $past(stamp_inc))))
    else $error("note on did not activate its voice or advance the stamp");

  a_release_all_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (op_r == OP_REL_ALL)) |=> (active_r == '0))
    else $error("release all left a voice active");

  a_write_ends_request: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_req.wr_en |=> ((state_r == ST_IDLE) && !tbl_req.rd_en))
    else $error("table write overlapped a scan");

  a_stamp_only_on_note_on: assert property (@(posedge clk) disable iff (!rst_n)
    !(fire && (op_r == OP_NOTE_ON)) |=> $stable(stamp_r))
    else $error("stamp counter moved without a note on");

endmodule

// ===== sv/synth_voice_allocator_top.sv =====
// Top level of the voice allocator: policy register, sequencer and result register.
//
//  Channel  Ports                                  Handshake
//  -------  -------------------------------------  -----------------
//  in       in_op in_note in_velocity in_needs_noise in_valid/in_ready
//  out      out_channel out_status                 out_valid/out_ready
//  cfg      cfg_wr_data (steal policy)             cfg_wr_en, no wait
//
// Note on and note off read the voice table memory one entry a cycle, then
// note on writes the chosen entry once; release all and unused opcodes skip
// the table scan.
// rst_n is synchronous: all voices go inactive, stamp and policy clear.
// A new request is accepted while a result waits in the output register;
// a stalled output holds the next result in the sequencer.
module synth_voice_allocator_top import sva_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_op,
  input  logic [6:0] in_note,
  input  logic [6:0] in_velocity,
  input  logic       in_needs_noise,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_channel,
  output logic [2:0] out_status,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data
);

  logic [1:0] policy_r;
  logic       out_valid_r;
  res_t       out_res_r;
  logic       res_valid;
  logic       res_ready;
  res_t       res;

  sva_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_note        (in_note),
    .in_velocity    (in_velocity),
    .in_needs_noise (in_needs_noise),
    .steal_policy   (policy_r),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .res            (res)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r    <= POL_OLDEST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        policy_r <= cfg_wr_data;
      end
      if (res_ready) begin
        out_valid_r <= res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_channel = out_res_r.channel;
  assign out_status  = out_res_r.status;

endmodule
